[hdl/tfr_pkg.sv]
`default_nettype none

package tfr_pkg;

    // palette depth default, top level parameter takes it from here
    localparam int unsigned PALETTE_ENTRIES_DEF = 256;

    // configuration register indexes
    localparam logic [1:0] CFG_TEXEL_FORMAT   = 2'd0;
    localparam logic [1:0] CFG_PALETTE_FORMAT = 2'd1;
    localparam logic [1:0] CFG_SWAP_ENDIAN    = 2'd2;

    // texel format codes, anything above RGBA32 decodes to magenta
    localparam logic [3:0] FMT_I4     = 4'd0;
    localparam logic [3:0] FMT_IA4    = 4'd1;
    localparam logic [3:0] FMT_CI4    = 4'd2;
    localparam logic [3:0] FMT_I8     = 4'd3;
    localparam logic [3:0] FMT_IA8    = 4'd4;
    localparam logic [3:0] FMT_CI8    = 4'd5;
    localparam logic [3:0] FMT_RGBA16 = 4'd6;
    localparam logic [3:0] FMT_RGBA32 = 4'd7;

    // palette entry layout code for rgba5551, other codes mean ia16
    localparam logic [1:0] PAL_RGBA5551 = 2'd2;

    // transaction commands
    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // 5-bit to 8-bit channel widening with rounding
    localparam logic [7:0] WIDEN5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
        8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
        8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
        8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
    };

    typedef struct packed {
        logic        cmd;
        logic [31:0] texel_bits;
        logic        odd_texel;
        logic [7:0]  palette_index;
        logic [15:0] palette_value;
    } texel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

endpackage

`default_nettype wire

[hdl/texel_format_to_rgba8888.sv]
// a decode transaction is registered in stage 1 with its palette read, then in the
// output register that drives pixel_data; a stalled pixel_ready holds it there
// throughput: one transaction per cycle unless stalled, palette writes and decodes
// mixed freely; a palette write is stored at the edge that accepts it and yields no pixel
// reset clears the pipeline valid flags and the three configuration registers;
// the palette memory is not cleared and holds garbage until written
`default_nettype none

module texel_format_to_rgba8888
    import tfr_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       texel_valid,
    output      logic       texel_ready,
    input  wire texel_t     texel_data,

    output      logic       pixel_valid,
    input  wire logic       pixel_ready,
    output      pixel_t     pixel_data,

    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [3:0] cfg_data
);

    // address width of the palette, index compare is wide enough that
    // the entry count itself fits and at least as wide as an 8-bit index
    localparam int unsigned ADDR_W = $clog2(PALETTE_ENTRIES);
    localparam int unsigned CMP_W  = $clog2(PALETTE_ENTRIES + 1);
    localparam int unsigned IDX_W  = (CMP_W > 8) ? CMP_W : 8;

    // configuration registers
    logic [3:0] texel_format_reg;
    logic [1:0] palette_format_reg;
    logic       swap_endian_reg;

    // palette memory, one write port and one registered read port
    logic [15:0] palette_mem [PALETTE_ENTRIES];
    logic [15:0] rd_data_reg;

    // stage 1: texel waiting for its palette read
    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_bits_reg;
    logic        s1_odd_reg;
    logic        s1_oor_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    pixel_t      out_data_reg;
    pixel_t      out_data_next;

    logic        accept;
    logic        out_free;
    logic        s1_advance;
    logic        is_decode;
    logic        wr_en;
    logic [7:0]  lut_idx;
    logic        lut_oor;
    logic [3:0]  in_nibble;

    // handshake: the output register frees when empty or taken, stage 1
    // moves on whenever the output register can take it
    assign out_free    = !out_valid_reg || pixel_ready;
    assign s1_advance  = s1_valid_reg && out_free;
    assign texel_ready = !s1_valid_reg || s1_advance;
    assign accept      = texel_valid && texel_ready;
    assign is_decode   = (texel_data.cmd == CMD_DECODE);

    assign pixel_valid = out_valid_reg;
    assign pixel_data  = out_data_reg;

    // palette lookup index: ci4 takes the selected nibble, ci8 the low byte
    assign in_nibble = texel_data.odd_texel ? texel_data.texel_bits[3:0]
                                            : texel_data.texel_bits[7:4];
    always_comb
    begin
        if (texel_format_reg == FMT_CI4)
        begin
            lut_idx = {4'd0, in_nibble};
        end
        else
        begin
            lut_idx = texel_data.texel_bits[7:0];
        end
    end

    // an index past the end of a smaller palette reads as zero
    assign lut_oor = (IDX_W'(lut_idx) >= IDX_W'(PALETTE_ENTRIES));

    // writes past the end of a smaller palette are dropped
    assign wr_en = accept && !is_decode &&
                   (IDX_W'(texel_data.palette_index) < IDX_W'(PALETTE_ENTRIES));

    // configuration writes, only while the pipeline is idle: the user's duty, not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texel_format_reg   <= FMT_I4;
            palette_format_reg <= 2'd0;
            swap_endian_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEXEL_FORMAT:   texel_format_reg   <= cfg_data;
                CFG_PALETTE_FORMAT: palette_format_reg <= cfg_data[1:0];
                CFG_SWAP_ENDIAN:    swap_endian_reg    <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // palette memory: a write lands at its accept edge, so any decode accepted
    // after it already reads the new entry; read data only moves when a
    // decode is accepted, so it holds while stage 1 stalls
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            palette_mem[texel_data.palette_index[ADDR_W-1:0]] <= texel_data.palette_value;
        end
        if (accept && is_decode)
        begin
            rd_data_reg <= palette_mem[lut_idx[ADDR_W-1:0]];
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept && is_decode)
        begin
            s1_bits_reg <= texel_data.texel_bits;
            s1_odd_reg  <= texel_data.odd_texel;
            s1_oor_reg  <= lut_oor;
        end
    end

    // pixel decode from stage 1 and the palette read data
    logic [15:0] pal_word;
    logic [7:0]  s1_byte;
    logic [3:0]  s1_nibble;
    logic [7:0]  nib_wide;
    logic [7:0]  alpha_wide;
    pixel_t      pal_pixel;
    pixel_t      p5551_pixel;

    assign pal_word   = s1_oor_reg ? 16'd0 : rd_data_reg;
    assign s1_byte    = s1_bits_reg[7:0];
    assign s1_nibble  = s1_odd_reg ? s1_byte[3:0] : s1_byte[7:4];
    // nibble times 17 is the nibble repeated
    assign nib_wide   = {s1_nibble, s1_nibble};
    assign alpha_wide = {s1_byte[3:0], s1_byte[3:0]};

    always_comb
    begin
        // palette entry as rgba5551 or ia16
        if (palette_format_reg == PAL_RGBA5551)
        begin
            pal_pixel.red   = WIDEN5[pal_word[15:11]];
            pal_pixel.green = WIDEN5[pal_word[10:6]];
            pal_pixel.blue  = WIDEN5[pal_word[5:1]];
            pal_pixel.alpha = {8{pal_word[0]}};
        end
        else
        begin
            pal_pixel.red   = pal_word[15:8];
            pal_pixel.green = pal_word[15:8];
            pal_pixel.blue  = pal_word[15:8];
            pal_pixel.alpha = pal_word[7:0];
        end

        // direct rgba5551 texel
        p5551_pixel.red   = WIDEN5[s1_bits_reg[15:11]];
        p5551_pixel.green = WIDEN5[s1_bits_reg[10:6]];
        p5551_pixel.blue  = WIDEN5[s1_bits_reg[5:1]];
        p5551_pixel.alpha = {8{s1_bits_reg[0]}};

        case (texel_format_reg)
            FMT_I4:
                out_data_next = '{red: nib_wide, green: nib_wide, blue: nib_wide,
                                  alpha: 8'hFF};
            FMT_IA4:
                out_data_next = '{red: {s1_byte[7:4], s1_byte[7:4]},
                                  green: {s1_byte[7:4], s1_byte[7:4]},
                                  blue: {s1_byte[7:4], s1_byte[7:4]},
                                  alpha: alpha_wide};
            FMT_CI4, FMT_CI8:
                out_data_next = pal_pixel;
            FMT_I8, FMT_IA8:
                out_data_next = '{red: s1_byte, green: s1_byte, blue: s1_byte,
                                  alpha: 8'hFF};
            FMT_RGBA16:
                out_data_next = p5551_pixel;
            FMT_RGBA32:
                if (swap_endian_reg)
                begin
                    out_data_next = '{red: s1_bits_reg[7:0], green: s1_bits_reg[15:8],
                                      blue: s1_bits_reg[23:16],
                                      alpha: s1_bits_reg[31:24]};
                end
                else
                begin
                    out_data_next = s1_bits_reg;
                end
            // unknown format shows as magenta
            default:
                out_data_next = '{red: 8'hFF, green: 8'h00, blue: 8'hFF, alpha: 8'hFF};
        endcase
    end

    // valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = is_decode;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

[hdl/tfr_checker.sv]
`default_nettype none

module tfr_checker
    import tfr_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       texel_valid,
    input wire logic       texel_ready,
    input wire texel_t     texel_data,
    input wire logic       pixel_valid,
    input wire logic       pixel_ready,
    input wire pixel_t     pixel_data
);

    logic accept;
    assign accept = texel_valid && texel_ready;

    // reset empties the output
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !pixel_valid)
        else $error("pixel valid during reset");

    // a stalled pixel holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_data))
        else $error("stalled pixel changed");

    // input only backs up when the output is stalled
    a_skid: assert property (@(posedge clk) disable iff (!rst_n)
        !texel_ready |-> pixel_valid && !pixel_ready)
        else $error("input blocked with output free");

    // nothing in flight means no pixel appears from nowhere
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_valid && !$past(accept) && !accept |=> !pixel_valid)
        else $error("pixel without a transaction");

    // a palette write into an empty pipe yields no pixel
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_valid && !$past(accept) && accept && texel_data.cmd == CMD_WRITE
        |=> !pixel_valid ##1 !pixel_valid)
        else $error("palette write produced a pixel");

endmodule

bind texel_format_to_rgba8888 tfr_checker u_tfr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .texel_valid (texel_valid),
    .texel_ready (texel_ready),
    .texel_data  (texel_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_data  (pixel_data)
);

`default_nettype wire

[tb/pixel_checker.sv]
`default_nettype none

module pixel_checker
    import tfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       texel_valid,
    input  wire logic       texel_ready,
    input  wire texel_t     texel_data,

    input  wire logic       pixel_valid,
    input  wire logic       pixel_ready,
    input  wire pixel_t     pixel_data,

    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [3:0] cfg_data,

    output int              pixels_owed,
    output int              pixels_checked,
    output int              mismatches
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam pixel_t MAGENTA = {8'hFF, 8'h00, 8'hFF, 8'hFF};

    logic [3:0]  texel_fmt;
    logic [1:0]  palette_fmt;
    logic        swap_bytes;
    logic [15:0] palette_mem [PALETTE_ENTRIES_DEF];
    pixel_t      pending_pixels [$];

    // 5-bit channel to 8 bits, rounded to nearest
    function automatic logic [7:0] widen5(input logic [4:0] c);
        int unsigned scaled;
        scaled = (int'(c) * 255 + 15) / 31;
        return scaled[7:0];
    endfunction

    function automatic pixel_t from_5551(input logic [15:0] c);
        return {widen5(c[15:11]), widen5(c[10:6]), widen5(c[5:1]), c[0] ? 8'hFF : 8'h00};
    endfunction

    function automatic pixel_t palette_color(input logic [15:0] entry);
        if (palette_fmt == PAL_RGBA5551)
            return from_5551(entry);
        return {entry[15:8], entry[15:8], entry[15:8], entry[7:0]};
    endfunction

    function automatic pixel_t decode_texel(input texel_t t);
        logic [7:0]  low_byte;
        logic [3:0]  nib;
        logic [31:0] b;
        logic [7:0]  v;
        b        = t.texel_bits;
        low_byte = b[7:0];
        nib      = t.odd_texel ? low_byte[3:0] : low_byte[7:4];
        v        = {nib, nib};
        case (texel_fmt)
            FMT_I4:              return {v, v, v, 8'hFF};
            FMT_IA4:             return {{3{low_byte[7:4], low_byte[7:4]}},
                                         low_byte[3:0], low_byte[3:0]};
            FMT_CI4:             return palette_color(palette_mem[{4'h0, nib}]);
            FMT_I8, FMT_IA8:     return {low_byte, low_byte, low_byte, 8'hFF};
            FMT_CI8:             return palette_color(palette_mem[low_byte]);
            FMT_RGBA16:          return from_5551(b[15:0]);
            FMT_RGBA32:          return swap_bytes ? {b[7:0], b[15:8], b[23:16], b[31:24]} : b;
            default:             return MAGENTA;
        endcase
    endfunction

    task automatic compare_channel(input string name, input logic [7:0] want,
                                   input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            texel_fmt      = FMT_I4;
            palette_fmt    = '0;
            swap_bytes     = 1'b0;
            pending_pixels.delete();
            pixels_owed    = 0;
            pixels_checked = 0;
            mismatches     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TEXEL_FORMAT:   texel_fmt   = cfg_data;
                    CFG_PALETTE_FORMAT: palette_fmt = cfg_data[1:0];
                    CFG_SWAP_ENDIAN:    swap_bytes  = cfg_data[0];
                    default:            ;
                endcase
            end

            if (pixel_valid && pixel_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("pixel transaction with nothing pending: %h", pixel_data);
                    mismatches++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    compare_channel("red",   want.red,   pixel_data.red);
                    compare_channel("green", want.green, pixel_data.green);
                    compare_channel("blue",  want.blue,  pixel_data.blue);
                    compare_channel("alpha", want.alpha, pixel_data.alpha);
                    pixels_checked++;
                end
            end

            if (texel_valid && texel_ready)
            begin
                if (texel_data.cmd == CMD_WRITE)
                    palette_mem[texel_data.palette_index] = texel_data.palette_value;
                else
                    pending_pixels.push_back(decode_texel(texel_data));
            end

            pixels_owed = pending_pixels.size();
        end
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;

    import tfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int PHASES          = 20;
    localparam int TAIL_PHASES     = 2;      // last phases run with no idling at all
    localparam int ITEMS_PER_PHASE = 95;
    localparam int EDGE_PHASES     = 8;      // phases that open with the edge texels
    localparam int CYCLE_LIMIT     = 200000;

    // register index past the end of the list, the block must ignore it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // format codes outside the decoded set, all give magenta
    localparam logic [3:0] FMT_MAGENTA_LO  = 4'd8;
    localparam logic [3:0] FMT_MAGENTA_MID = 4'd12;
    localparam logic [3:0] FMT_MAGENTA_HI  = 4'd15;

    // palette layout codes that mean ia16
    localparam logic [1:0] PAL_IA16_LO  = 2'd0;
    localparam logic [1:0] PAL_IA16_MID = 2'd1;
    localparam logic [1:0] PAL_IA16_HI  = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       texel_valid;
    logic       texel_ready;
    texel_t     texel_data;
    logic       pixel_valid;
    logic       pixel_ready = 1'b0;
    pixel_t     pixel_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;

    int pixels_owed;
    int pixels_checked;
    int mismatches;

    // register settings per phase: every format, every palette layout,
    // both byte orders, and the extremes of each register
    logic [3:0] phase_fmt [PHASES] = '{
        FMT_I4, FMT_IA4, FMT_CI4, FMT_I8, FMT_IA8, FMT_CI8, FMT_RGBA16, FMT_RGBA32,
        FMT_RGBA32, FMT_CI4, FMT_CI8, FMT_CI4, FMT_CI8, FMT_MAGENTA_LO, FMT_MAGENTA_HI,
        FMT_MAGENTA_MID, FMT_CI8, FMT_RGBA16, FMT_RGBA32, FMT_I4
    };
    logic [1:0] phase_pal [PHASES] = '{
        PAL_IA16_LO, PAL_IA16_MID, PAL_IA16_LO, PAL_IA16_HI, PAL_RGBA5551, PAL_IA16_MID,
        PAL_IA16_LO, PAL_IA16_LO, PAL_IA16_HI, PAL_RGBA5551, PAL_RGBA5551, PAL_IA16_HI,
        PAL_IA16_LO, PAL_RGBA5551, PAL_IA16_LO, PAL_IA16_MID, PAL_RGBA5551, PAL_IA16_HI,
        PAL_RGBA5551, PAL_IA16_HI
    };
    logic       phase_swap [PHASES] = '{
        1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1
    };

    // stimulus side bookkeeping
    logic [3:0] cur_fmt;
    logic       palette_loaded [256];
    int         send_gap_odds;      // 0 means the sender never pauses
    int         ready_gap_odds;     // 0 means the receiver never stalls
    int         stall_left;
    int         texels_sent;
    int         palette_writes;
    int         settings_applied;
    int         cycle_count;

    texel_format_to_rgba8888 DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .texel_valid (texel_valid),
        .texel_ready (texel_ready),
        .texel_data  (texel_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_data  (pixel_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // watches both channels and the register port, predicts and compares
    pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .texel_valid    (texel_valid),
        .texel_ready    (texel_ready),
        .texel_data     (texel_data),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel_data     (pixel_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixels_owed    (pixels_owed),
        .pixels_checked (pixels_checked),
        .mismatches     (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels still owed", cycle_count, pixels_owed);
            $display("FAIL texel_format_to_rgba8888");
            $finish;
        end
    end

    // pixel receiver: ready drops at random, in bursts that stall_left stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_ready <= 1'b0;
            stall_left  = 0;
        end
        else if (stall_left > 0)
        begin
            pixel_ready <= 1'b0;
            stall_left--;
        end
        else if (ready_gap_odds != 0 && $urandom_range(1, ready_gap_odds) == 1)
        begin
            pixel_ready <= 1'b0;
            stall_left  = $urandom_range(0, 2);
        end
        else
        begin
            pixel_ready <= 1'b1;
        end
    end

    // one register write; the wait after lowering cfg_we keeps it from being
    // lowered and raised again in the same step
    task automatic cfg_write(input logic [1:0] idx, input logic [3:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // offer one texel transaction and hold it until texel_ready reads high after an
    // edge; valid stays high into the next call unless a sender pause comes first
    task automatic send_texel(input texel_t t);
        if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1)
        begin
            texel_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        texel_valid <= 1'b1;
        texel_data  <= t;
        @(posedge clk);
        while (!texel_ready)
            @(posedge clk);
        texels_sent++;
        if (t.cmd == CMD_WRITE)
        begin
            palette_loaded[t.palette_index] = 1'b1;
            palette_writes++;
        end
    endtask

    // palette write with noise in the fields the write does not use
    task automatic send_palette(input logic [7:0] idx, input logic [15:0] value);
        texel_t t;
        t.cmd           = CMD_WRITE;
        t.texel_bits    = $urandom;
        t.odd_texel     = $urandom_range(0, 1);
        t.palette_index = idx;
        t.palette_value = value;
        send_texel(t);
    endtask

    task automatic send_decode(input logic [31:0] bits, input logic odd);
        texel_t t;
        t.cmd           = CMD_DECODE;
        t.texel_bits    = bits;
        t.odd_texel     = odd;
        t.palette_index = $urandom_range(0, 255);
        t.palette_value = $urandom_range(0, 65535);
        send_texel(t);
    endtask

    // random transaction; palette lookups only ever hit loaded entries,
    // a missing entry gets written just ahead of the decode
    task automatic random_texel();
        texel_t     t;
        logic [7:0] slot;
        logic       ci_fmt;
        ci_fmt          = (cur_fmt == FMT_CI4) || (cur_fmt == FMT_CI8);
        t.cmd           = ($urandom_range(0, 99) < (ci_fmt ? 25 : 10)) ? CMD_WRITE : CMD_DECODE;
        t.texel_bits    = $urandom;
        t.odd_texel     = $urandom_range(0, 1);
        t.palette_index = $urandom_range(0, 255);
        t.palette_value = $urandom_range(0, 65535);
        // in 4-bit indexed mode keep rewriting the sixteen reachable entries
        if (cur_fmt == FMT_CI4 && $urandom_range(0, 3) != 0)
            t.palette_index = {4'h0, t.palette_index[3:0]};
        if (cur_fmt == FMT_CI8)
            slot = t.texel_bits[7:0];
        else
            slot = {4'h0, t.odd_texel ? t.texel_bits[3:0] : t.texel_bits[7:4]};
        if (t.cmd == CMD_DECODE && ci_fmt && !palette_loaded[slot])
            send_palette(slot, 16'($urandom));
        send_texel(t);
    endtask

    // wait until every predicted pixel has come out, then let the
    // two-stage pipe settle before registers are touched
    task automatic drain_pixels(input int settle);
        texel_valid <= 1'b0;
        @(posedge clk);
        while (pixels_owed != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    initial
    begin
        int p;
        int n;
        rst_n            = 1'b0;
        texel_valid      = 1'b0;
        texel_data       = '0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_TEXEL_FORMAT;
        cfg_data         = '0;
        cur_fmt          = FMT_I4;
        send_gap_odds    = 4;
        ready_gap_odds   = 4;
        texels_sent      = 0;
        palette_writes   = 0;
        settings_applied = 0;
        foreach (palette_loaded[i])
            palette_loaded[i] = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // palette entries that the edge texels reach: index 0 for an all-zero
        // texel, 15 and 255 for an all-ones texel in 4-bit and 8-bit modes
        send_palette(8'h00, 16'h0000);
        send_palette(8'h0F, 16'hFFFF);
        send_palette(8'hFF, 16'h8001);

        for (p = 0; p < PHASES; p++)
        begin
            drain_pixels(4);

            // full 4-bit data on the narrow registers: upper bits must be dropped
            cur_fmt = phase_fmt[p];
            cfg_write(CFG_TEXEL_FORMAT, phase_fmt[p]);
            cfg_write(CFG_PALETTE_FORMAT, {2'($urandom), phase_pal[p]});
            cfg_write(CFG_SWAP_ENDIAN, {3'($urandom), phase_swap[p]});
            cfg_write(CFG_UNUSED, 4'($urandom));
            settings_applied++;

            // idling pattern: calm every fourth phase and through the tail
            if (p >= PHASES - TAIL_PHASES || p % 4 == 3)
            begin
                send_gap_odds  = 0;
                ready_gap_odds = 0;
            end
            else
            begin
                send_gap_odds  = $urandom_range(2, 6);
                ready_gap_odds = $urandom_range(2, 6);
            end

            // edge texels: all zeros, all ones on both nibble selects
            if (p < EDGE_PHASES)
            begin
                send_decode(32'h0000_0000, 1'b0);
                send_decode(32'hFFFF_FFFF, 1'b0);
                send_decode(32'hFFFF_FFFF, 1'b1);
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++)
                random_texel();
        end

        drain_pixels(8);

        $display("sent %0d texel transactions (%0d palette writes) under %0d register settings",
                 texels_sent, palette_writes, settings_applied);
        $display("checked %0d pixels, %0d mismatches", pixels_checked, mismatches);
        if (mismatches == 0)
            $display("PASS texel_format_to_rgba8888");
        else
            $display("FAIL texel_format_to_rgba8888");
        $finish;
    end

endmodule

`default_nettype wire

[texel_format_to_rgba8888.f]
hdl/tfr_pkg.sv
hdl/texel_format_to_rgba8888.sv
hdl/tfr_checker.sv
tb/pixel_checker.sv
tb/testbench.sv
